// ===== hdl/dltd_pkg.sv =====
// Shared types and constants for the detection log dedupe table.
// Used by dltd_front, dltd_back and the top level; depends on nothing.
package dltd_pkg;

  typedef enum logic [2:0] {
    K_BLE    = 3'd0,
    K_WIFI   = 3'd1,
    K_PUSH   = 3'd2,
    K_EXPIRE = 3'd3,
    K_READ   = 3'd4,
    K_CLEAR  = 3'd5,
    K_LIFE   = 3'd6,
    K_NONE   = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    OP_SIGHT,
    OP_PUSH,
    OP_EXPIRE,
    OP_READ,
    OP_CLEAR,
    OP_LIFE,
    OP_IGNORE
  } op_t;

  typedef enum logic [2:0] {
    RS_APPENDED   = 3'd0,
    RS_MERGED     = 3'd1,
    RS_REACT      = 3'd2,
    RS_IGNORED    = 3'd3,
    RS_EXPIRED    = 3'd4,
    RS_CLEARED    = 3'd5,
    RS_READ_OK    = 3'd6,
    RS_READ_EMPTY = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXPIRE,
    S_MERGE,
    S_APPEND,
    S_READ
  } state_t;

  typedef struct packed {
    op_t                op;
    logic               wifi;
    logic [47:0]        mac;
    logic [3:0]         typ;
    logic signed [7:0]  rssi;
    logic [3:0]         chan;
    logic [31:0]        now;
    logic [15:0]        phits;
    logic [5:0]         ridx;
  } item_t;

  typedef struct packed {
    logic [47:0]        mac;
    logic [3:0]         typ;
    logic signed [7:0]  rssi;
    logic [3:0]         chan;
    logic [31:0]        first;
    logic [31:0]        last;
    logic [15:0]        hits;
    logic               live;
  } entry_t;

  typedef struct packed {
    status_t            status;
    logic [5:0]         slot;
    entry_t             ent;
    logic [15:0]        tcount;
    logic [31:0]        total;
  } result_t;

  localparam logic [15:0] CNT_MAX     = 16'hFFFF;
  localparam logic [31:0] TOTAL_MAX   = 32'hFFFF_FFFF;
  localparam logic [31:0] STALE_RESET = 32'd30000;

endpackage

// ===== hdl/dltd_front.sv =====
// Front end: accepts requests, classifies them and holds them in a
// two-entry queue for the back end. Depends on dltd_pkg.
module dltd_front import dltd_pkg::*; #(
  parameter int TYPE_CODES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [47:0] dev_mac,
  input  logic [3:0]  dev_type,
  input  logic signed [7:0] signal_dbm,
  input  logic [3:0]  radio_channel,
  input  logic [31:0] now_ms,
  input  logic [15:0] push_hits,
  input  logic [5:0]  read_index,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      cls;
  logic       bad_push;
  logic       bad_sight;
  logic       push;

  assign bad_push  = {1'b0, dev_type} >= 5'(TYPE_CODES);
  assign bad_sight = (dev_type == 4'd0) || bad_push;

  always_comb begin
    cls.wifi  = (kind_t'(kind) == K_WIFI);
    cls.mac   = dev_mac;
    cls.typ   = dev_type;
    cls.rssi  = signal_dbm;
    cls.chan  = radio_channel;
    cls.now   = now_ms;
    cls.phits = push_hits;
    cls.ridx  = read_index;
    case (kind_t'(kind))
      K_BLE, K_WIFI: cls.op = bad_sight ? OP_IGNORE : OP_SIGHT;
      K_PUSH:        cls.op = bad_push ? OP_IGNORE : OP_PUSH;
      K_EXPIRE:      cls.op = OP_EXPIRE;
      K_READ:        cls.op = OP_READ;
      K_CLEAR:       cls.op = OP_CLEAR;
      K_LIFE:        cls.op = OP_LIFE;
      default:       cls.op = OP_IGNORE;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/dltd_back.sv =====
// Back end: log memory, ring pointers, per-type counters and the walk
// sequencer that carries out each request. Depends on dltd_pkg.
module dltd_back import dltd_pkg::*; #(
  parameter int LOG_ENTRIES = 64,
  parameter int TYPE_CODES  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output result_t     res
);

  localparam int IW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
  localparam int FW = $clog2(LOG_ENTRIES + 1);
  localparam int TW = (TYPE_CODES > 1) ? $clog2(TYPE_CODES) : 1;

  entry_t        mem [LOG_ENTRIES];
  entry_t        rd;
  state_t        state, state_next;
  item_t         cur;
  logic [FW-1:0] age, age_next;
  logic          chk_valid, chk_valid_next;
  logic          chk_last, chk_last_next;
  logic [IW-1:0] chk_slot, chk_slot_next;
  logic [IW-1:0] head;
  logic [FW-1:0] fill;
  logic [15:0]   cnt [TYPE_CODES];
  logic [31:0]   total;
  logic [31:0]   stale;
  logic [15:0]   nexp, nexp_next;

  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;
  logic          produce;
  result_t       res_next;
  logic          inc_en, dec_en, cnt_clear;
  logic [3:0]    inc_idx, dec_idx;
  logic          do_append, do_clear, total_clear;
  logic          out_free;
  logic          hit, expires, react;
  entry_t        merged, fresh;
  item_t         work;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] hp,
                                            input logic [FW-1:0] a);
    logic [IW:0] t;
    t = (IW+1)'(hp) + (IW+1)'(LOG_ENTRIES - 1) - (IW+1)'(a);
    if (t >= (IW+1)'(LOG_ENTRIES)) begin
      t = t - (IW+1)'(LOG_ENTRIES);
    end
    return IW'(t);
  endfunction

  function automatic logic [15:0] cnt_of(input logic [3:0] t);
    logic [15:0] v;
    v = 16'd0;
    if ({1'b0, t} < 5'(TYPE_CODES)) begin
      v = cnt[t[TW-1:0]];
    end
    return v;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && q_valid && out_free;
  assign work     = (state == S_IDLE) ? q_item : cur;

  assign hit     = (rd.mac == cur.mac) && (rd.typ == cur.typ);
  assign expires = rd.live && ((cur.now - rd.last) > stale);
  assign react   = !rd.live;

  always_comb begin
    merged      = rd;
    merged.rssi = cur.rssi;
    merged.last = cur.now;
    if (cur.wifi) begin
      merged.chan = cur.chan;
    end
    if (cur.wifi || react) begin
      merged.hits = sat_inc(rd.hits);
    end
    if (react) begin
      merged.live  = 1'b1;
      merged.first = cur.now;
    end
  end

  always_comb begin
    fresh.mac   = cur.mac;
    fresh.typ   = cur.typ;
    fresh.rssi  = cur.rssi;
    fresh.chan  = (cur.op == OP_SIGHT && !cur.wifi) ? 4'd0 : cur.chan;
    fresh.first = cur.now;
    fresh.last  = cur.now;
    fresh.hits  = (cur.op == OP_PUSH) ? cur.phits : 16'd1;
    fresh.live  = 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_pop) begin
          case (work.op)
            OP_SIGHT:  state_next = (fill == '0) ? S_APPEND : S_SCAN;
            OP_PUSH:   state_next = S_APPEND;
            OP_EXPIRE: state_next = (fill == '0) ? S_IDLE : S_EXPIRE;
            OP_READ:   state_next = (9'(work.ridx) >= 9'(fill)) ? S_IDLE : S_READ;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (chk_valid && hit) begin
          state_next = S_MERGE;
        end else if (chk_valid && chk_last) begin
          state_next = S_APPEND;
        end
      end
      S_EXPIRE: begin
        if (chk_valid && chk_last) begin
          state_next = S_IDLE;
        end
      end
      S_MERGE, S_APPEND, S_READ: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    rd_en          = 1'b0;
    rd_addr        = slot_of(head, age);
    wr_en          = 1'b0;
    wr_addr        = head;
    wr_data        = rd;
    produce        = 1'b0;
    inc_en         = 1'b0;
    inc_idx        = work.typ;
    dec_en         = 1'b0;
    dec_idx        = rd.typ;
    cnt_clear      = 1'b0;
    do_append      = 1'b0;
    do_clear       = 1'b0;
    total_clear    = 1'b0;
    age_next       = age;
    chk_valid_next = 1'b0;
    chk_last_next  = chk_last;
    nexp_next      = nexp;
    res_next.status = RS_IGNORED;
    res_next.slot   = 6'd0;
    res_next.ent    = '0;
    res_next.tcount = 16'd0;
    res_next.total  = total;

    case (state)
      S_IDLE: begin
        age_next  = '0;
        nexp_next = 16'd0;
        if (q_pop) begin
          case (work.op)
            OP_EXPIRE: begin
              if (fill == '0) begin
                produce         = 1'b1;
                res_next.status = RS_EXPIRED;
              end
            end
            OP_READ: begin
              if (9'(work.ridx) >= 9'(fill)) begin
                produce         = 1'b1;
                res_next.status = RS_READ_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = slot_of(head, FW'(work.ridx));
              end
            end
            OP_CLEAR: begin
              produce         = 1'b1;
              res_next.status = RS_CLEARED;
              do_clear        = 1'b1;
              cnt_clear       = 1'b1;
            end
            OP_LIFE: begin
              produce         = 1'b1;
              res_next.status = RS_CLEARED;
              res_next.total  = 32'd0;
              total_clear     = 1'b1;
              cnt_clear       = 1'b1;
            end
            OP_SIGHT, OP_PUSH: begin
            end
            default: begin
              produce = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // issue the next age while the previous read is compared
        if (!(chk_valid && (hit || chk_last)) && (age < fill)) begin
          rd_en          = 1'b1;
          chk_valid_next = 1'b1;
          chk_last_next  = (FW'(age + 1'b1) == fill);
          age_next       = FW'(age + 1'b1);
        end
      end
      S_EXPIRE: begin
        if (!(chk_valid && chk_last) && (age < fill)) begin
          rd_en          = 1'b1;
          chk_valid_next = 1'b1;
          chk_last_next  = (FW'(age + 1'b1) == fill);
          age_next       = FW'(age + 1'b1);
        end
        if (chk_valid && expires) begin
          wr_en        = 1'b1;
          wr_addr      = chk_slot;
          wr_data      = rd;
          wr_data.live = 1'b0;
          dec_en       = 1'b1;
          nexp_next    = nexp + 16'd1;
        end
        if (chk_valid && chk_last) begin
          produce         = 1'b1;
          res_next.status = RS_EXPIRED;
          res_next.ent.hits = nexp_next;
        end
      end
      S_MERGE: begin
        wr_en           = 1'b1;
        wr_addr         = chk_slot;
        wr_data         = merged;
        inc_en          = react;
        produce         = 1'b1;
        res_next.status = react ? RS_REACT : RS_MERGED;
        res_next.slot   = 6'(chk_slot);
        res_next.ent    = merged;
        res_next.tcount = react ? sat_inc(cnt_of(cur.typ)) : cnt_of(cur.typ);
      end
      S_APPEND: begin
        wr_en           = 1'b1;
        wr_addr         = head;
        wr_data         = fresh;
        inc_en          = 1'b1;
        do_append       = 1'b1;
        produce         = 1'b1;
        res_next.status = RS_APPENDED;
        res_next.slot   = 6'(head);
        res_next.ent    = fresh;
        res_next.tcount = sat_inc(cnt_of(cur.typ));
        res_next.total  = (total == TOTAL_MAX) ? total : total + 32'd1;
      end
      S_READ: begin
        produce         = 1'b1;
        res_next.status = RS_READ_OK;
        res_next.slot   = 6'(chk_slot);
        res_next.ent    = rd;
        res_next.tcount = cnt_of(rd.typ);
      end
      default: begin
      end
    endcase
    chk_slot_next = rd_en ? rd_addr : chk_slot;
  end

  // log memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (produce) begin
      res <= res_next;
    end
    age      <= age_next;
    chk_slot <= chk_slot_next;
    chk_last <= chk_last_next;
    nexp     <= nexp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chk_valid <= 1'b0;
      head      <= '0;
      fill      <= '0;
      total     <= 32'd0;
      stale     <= STALE_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < TYPE_CODES; i++) begin
        cnt[i] <= 16'd0;
      end
    end else begin
      state     <= state_next;
      chk_valid <= chk_valid_next;
      if (cfg_we) begin
        stale <= cfg_data;
      end
      if (produce) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (do_clear) begin
        head <= '0;
        fill <= '0;
      end else if (do_append) begin
        head <= (head == IW'(LOG_ENTRIES - 1)) ? '0 : IW'(head + 1'b1);
        if (fill < FW'(LOG_ENTRIES)) begin
          fill <= FW'(fill + 1'b1);
        end
        if (total != TOTAL_MAX) begin
          total <= total + 32'd1;
        end
      end
      if (total_clear) begin
        total <= 32'd0;
      end
      for (int i = 0; i < TYPE_CODES; i++) begin
        if (cnt_clear) begin
          cnt[i] <= 16'd0;
        end else if (inc_en && ({1'b0, inc_idx} == 5'(i)) && cnt[i] != CNT_MAX) begin
          cnt[i] <= cnt[i] + 16'd1;
        end else if (dec_en && ({1'b0, dec_idx} == 5'(i)) && cnt[i] != 16'd0) begin
          cnt[i] <= cnt[i] - 16'd1;
        end
      end
    end
  end

endmodule

// ===== hdl/detection_log_dedupe_table_core.sv =====
// Detection log with dedupe: top level joining the front end queue and the
// back end sequencer. A sighting or an expire tick walks the log one entry per
// cycle through the log memory read port. One request at a time in the back
// end: it takes no new request until it is through with the last one.
// Reset (rst, synchronous) empties the log and zeroes counters and totals;
// the stale time returns to 30000 ms. The log memory itself is not cleared.
module detection_log_dedupe_table_core import dltd_pkg::*; #(
  parameter int LOG_ENTRIES = 64,
  parameter int TYPE_CODES  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [47:0] dev_mac,
  input  logic [3:0]  dev_type,
  input  logic signed [7:0] signal_dbm,
  input  logic [3:0]  radio_channel,
  input  logic [31:0] now_ms,
  input  logic [15:0] push_hits,
  input  logic [5:0]  read_index,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [5:0]  slot,
  output logic [47:0] entry_mac,
  output logic [3:0]  entry_type,
  output logic signed [7:0] entry_rssi,
  output logic [3:0]  entry_channel,
  output logic [31:0] entry_first_seen,
  output logic [31:0] entry_last_seen,
  output logic [15:0] entry_hits,
  output logic        entry_active,
  output logic [15:0] type_active_count,
  output logic [31:0] lifetime_total
);

  logic    q_valid;
  logic    q_pop;
  item_t   q_item;
  result_t res;

  // Front end: classify each request and hold it while the back end works.
  dltd_front #(
    .TYPE_CODES (TYPE_CODES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .dev_mac       (dev_mac),
    .dev_type      (dev_type),
    .signal_dbm    (signal_dbm),
    .radio_channel (radio_channel),
    .now_ms        (now_ms),
    .push_hits     (push_hits),
    .read_index    (read_index),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // Back end: walk the log, merge or append, and hold the result register.
  dltd_back #(
    .LOG_ENTRIES (LOG_ENTRIES),
    .TYPE_CODES  (TYPE_CODES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // Drive the result fields straight from the result register.
  assign status            = res.status;
  assign slot              = res.slot;
  assign entry_mac         = res.ent.mac;
  assign entry_type        = res.ent.typ;
  assign entry_rssi        = res.ent.rssi;
  assign entry_channel     = res.ent.chan;
  assign entry_first_seen  = res.ent.first;
  assign entry_last_seen   = res.ent.last;
  assign entry_hits        = res.ent.hits;
  assign entry_active      = res.ent.live;
  assign type_active_count = res.tcount;
  assign lifetime_total    = res.total;

endmodule
